// ===== design/poasq_pkg.sv =====
package poasq_pkg;

  // Table size
  localparam int SLOTS_DEF = 16;

  // Field widths
  localparam int ID_W     = 16;
  localparam int TIME_W   = 32;
  localparam int PRIO_W   = 8;
  localparam int STAT_W   = 2;
  localparam int CNT_W    = 5;
  localparam int CFG_W    = 5;
  localparam int CFG_IDX_W = 1;

  // Request codes
  localparam logic ACT_ADD = 1'b0;
  localparam logic ACT_POP = 1'b1;

  // Ordering modes
  localparam logic MODE_AGE  = 1'b0;
  localparam logic MODE_PRIO = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ORDER_MODE   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOTS_IN_USE = 1'b1;

  // Register reset values
  localparam logic             ORDER_MODE_RST   = MODE_AGE;
  localparam logic [CFG_W-1:0] SLOTS_IN_USE_RST = 5'd16;

  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] tstamp;
    logic [PRIO_W-1:0] prio;
  } entry_t;

  // Control from the sequencer to the compare unit
  typedef struct packed {
    logic clear;
    logic cand_vld;
    logic mode;
  } cmp_ctl_t;

  // Running winner held by the compare unit
  typedef struct packed {
    logic   found;
    entry_t entry;
  } best_t;

endpackage

// ===== design/poasq_if.sv =====
interface poasq_in_if;
  logic                          valid;
  logic                          ready;
  logic                          action;
  logic [poasq_pkg::ID_W-1:0]    conn_id;
  logic [poasq_pkg::TIME_W-1:0]  arrival_time;
  logic [poasq_pkg::PRIO_W-1:0]  prio;

  modport source (output valid, action, conn_id, arrival_time, prio, input ready);
  modport sink   (input valid, action, conn_id, arrival_time, prio, output ready);
endinterface

interface poasq_out_if;
  logic                          valid;
  logic                          ready;
  logic [poasq_pkg::STAT_W-1:0]  status;
  logic [poasq_pkg::ID_W-1:0]    out_id;
  logic [poasq_pkg::TIME_W-1:0]  out_time;
  logic [poasq_pkg::PRIO_W-1:0]  out_prio;
  logic [poasq_pkg::CNT_W-1:0]   occupancy;

  modport source (output valid, status, out_id, out_time, out_prio, occupancy, input ready);
  modport sink   (input valid, status, out_id, out_time, out_prio, occupancy, output ready);
endinterface

// ===== design/priority_or_age_slot_queue_top.sv =====
// Channel   Modport  Direction  Word
// in_if     sink     input      action, conn_id, arrival_time, prio
// out_if    source   output     status, out_id, out_time, out_prio, occupancy
// cfg_*     plain    input      write enable, register index, write data
//
// An add scans from slot 0 and stops at the first free slot, or after all lim usable
// slots when they are all taken. A pop reads every usable slot before it answers.
// lim is slots_in_use capped at SLOTS. The scan goes one slot per cycle; a pop reads
// through the single read port of the slot memory into one shared compare unit.
// Reset is synchronous and active low; it clears the valid bits and count and sets the registers to their reset values.
// A result that is not taken holds the block in its last step, with input not ready.

module priority_or_age_slot_queue_top #(
  parameter int SLOTS = poasq_pkg::SLOTS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  poasq_in_if.sink                          in_if,
  poasq_out_if.source                       out_if,
  input  logic                              cfg_we,
  input  logic [poasq_pkg::CFG_IDX_W-1:0]   cfg_idx,
  input  logic [poasq_pkg::CFG_W-1:0]       cfg_wdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam int EW = $bits(poasq_pkg::entry_t);

  // Sequencer state and the request being served.
  poasq_pkg::state_t          state_r, state_nxt;
  logic                       act_r, act_nxt;
  poasq_pkg::entry_t          req_r, req_nxt;
  logic [CW-1:0]              lim_r, lim_nxt;
  logic [CW-1:0]              idx_r, idx_nxt;
  logic                       free_found_r, free_found_nxt;
  logic [IW-1:0]              free_idx_r, free_idx_nxt;

  // Slot bookkeeping. The slot fields live in the memory; a slot's fields are
  // only read while its valid bit is set, so the memory needs no clearing.
  logic [SLOTS-1:0]           valid_r, valid_nxt;
  logic [poasq_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  // Configuration registers.
  logic                       mode_r, mode_nxt;
  logic [poasq_pkg::CFG_W-1:0] siu_r, siu_nxt;

  // The memory read is registered, so the candidate's valid flag and index are registered alongside it.
  logic                       rd_vld_r, rd_vld_nxt;
  logic [IW-1:0]              rd_idx_r, rd_idx_nxt;

  // Result register, which frees the scan side while a word waits downstream.
  logic                       out_valid_r, out_valid_nxt;
  logic [poasq_pkg::STAT_W-1:0] out_stat_r, out_stat_nxt;
  poasq_pkg::entry_t          out_entry_r, out_entry_nxt;
  logic [poasq_pkg::CNT_W-1:0] out_occ_r, out_occ_nxt;

  // Memory and compare unit hookup.
  logic                       ram_we;
  logic [IW-1:0]              ram_waddr;
  logic [IW-1:0]              ram_raddr;
  logic [EW-1:0]              ram_rdata;
  poasq_pkg::cmp_ctl_t        cmp_ctl;
  poasq_pkg::best_t           best;
  logic [IW-1:0]              best_idx;

  logic                       in_acc;
  logic                       out_free;
  logic                       scan_done;
  logic [IW-1:0]              cur;
  logic                       cur_valid;

  assign in_if.ready = (state_r == poasq_pkg::S_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign out_free    = !out_valid_r || out_if.ready;
  assign scan_done   = (idx_r == lim_r);
  assign cur         = idx_r[IW-1:0];
  assign cur_valid   = valid_r[cur];

  poasq_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (req_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  poasq_cmp #(
    .SLOTS (SLOTS)
  ) u_cmp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (cmp_ctl),
    .cand_idx (rd_idx_r),
    .cand     (poasq_pkg::entry_t'(ram_rdata)),
    .best     (best),
    .best_idx (best_idx)
  );

  assign cmp_ctl.clear    = in_acc;
  assign cmp_ctl.cand_vld = rd_vld_r;
  assign cmp_ctl.mode     = mode_r;

  // Configuration writes. Only legal while idle, so no interlock with the scan.
  always_comb begin
    mode_nxt = mode_r;
    siu_nxt  = siu_r;
    if (cfg_we) begin
      case (cfg_idx)
        poasq_pkg::REG_ORDER_MODE:   mode_nxt = cfg_wdata[0];
        poasq_pkg::REG_SLOTS_IN_USE: siu_nxt  = cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sequencer: next state and outputs.
  always_comb begin
    state_nxt      = state_r;
    act_nxt        = act_r;
    req_nxt        = req_r;
    lim_nxt        = lim_r;
    idx_nxt        = idx_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    cnt_nxt        = cnt_r;
    rd_vld_nxt     = 1'b0;
    rd_idx_nxt     = cur;
    ram_we         = 1'b0;
    ram_waddr      = free_idx_r;
    ram_raddr      = cur;
    out_valid_nxt  = out_valid_r && !out_if.ready;
    out_stat_nxt   = out_stat_r;
    out_entry_nxt  = out_entry_r;
    out_occ_nxt    = out_occ_r;

    case (state_r)
      poasq_pkg::S_IDLE: begin
        if (in_acc) begin
          act_nxt        = in_if.action;
          req_nxt.id     = in_if.conn_id;
          req_nxt.tstamp = in_if.arrival_time;
          req_nxt.prio   = in_if.prio;
          // Usable slots are the programmed count capped at the table size.
          if (32'(siu_r) > SLOTS) begin
            lim_nxt = CW'(SLOTS);
          end else begin
            lim_nxt = CW'(siu_r);
          end
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          state_nxt      = poasq_pkg::S_SCAN;
        end
      end

      poasq_pkg::S_SCAN: begin
        if (act_r == poasq_pkg::ACT_ADD) begin
          // First free slot wins; stop as soon as one turns up.
          if (scan_done) begin
            state_nxt = poasq_pkg::S_FINISH;
          end else if (!cur_valid) begin
            free_found_nxt = 1'b1;
            free_idx_nxt   = cur;
            state_nxt      = poasq_pkg::S_FINISH;
          end else begin
            idx_nxt = idx_r + CW'(1);
          end
        end else begin
          // Pop reads every usable slot; the compare unit keeps the winner.
          if (scan_done) begin
            state_nxt = poasq_pkg::S_DRAIN;
          end else begin
            rd_vld_nxt = cur_valid;
            idx_nxt    = idx_r + CW'(1);
          end
        end
      end

      poasq_pkg::S_DRAIN: begin
        // The last candidate was compared at the end of the scan; this is a
        // spare cycle before the result is formed.
        state_nxt = poasq_pkg::S_FINISH;
      end

      poasq_pkg::S_FINISH: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_entry_nxt = '0;
          state_nxt     = poasq_pkg::S_IDLE;
          if (act_r == poasq_pkg::ACT_ADD) begin
            if (free_found_r) begin
              ram_we                 = 1'b1;
              valid_nxt[free_idx_r]  = 1'b1;
              cnt_nxt                = cnt_r + poasq_pkg::CNT_W'(1);
              out_stat_nxt           = poasq_pkg::ST_OK;
            end else begin
              out_stat_nxt = poasq_pkg::ST_FULL;
            end
          end else begin
            if (best.found) begin
              valid_nxt[best_idx] = 1'b0;
              if (cnt_r != '0) begin
                cnt_nxt = cnt_r - poasq_pkg::CNT_W'(1);
              end
              out_entry_nxt = best.entry;
              out_stat_nxt  = poasq_pkg::ST_OK;
            end else begin
              out_stat_nxt = poasq_pkg::ST_EMPTY;
            end
          end
          out_occ_nxt = cnt_nxt;
        end
      end

      default: begin
        state_nxt = poasq_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= poasq_pkg::S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      mode_r      <= poasq_pkg::ORDER_MODE_RST;
      siu_r       <= poasq_pkg::SLOTS_IN_USE_RST;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      mode_r      <= mode_nxt;
      siu_r       <= siu_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r        <= act_nxt;
    req_r        <= req_nxt;
    lim_r        <= lim_nxt;
    idx_r        <= idx_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    rd_idx_r     <= rd_idx_nxt;
    out_stat_r   <= out_stat_nxt;
    out_entry_r  <= out_entry_nxt;
    out_occ_r    <= out_occ_nxt;
  end

  assign out_if.valid     = out_valid_r;
  assign out_if.status    = out_stat_r;
  assign out_if.out_id    = out_entry_r.id;
  assign out_if.out_time  = out_entry_r.tstamp;
  assign out_if.out_prio  = out_entry_r.prio;
  assign out_if.occupancy = out_occ_r;

`ifndef ASSERT_OFF
  // The entry count always matches the number of valid slots.
  a_count_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_r) == int'(cnt_r))
    else $error("entry count out of step with valid bits");

  // An accepted request always starts a scan.
  a_accept_scans: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r == poasq_pkg::S_SCAN)
    else $error("accepted request did not start a scan");

  // A committed add lands in a slot that was free.
  a_add_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == poasq_pkg::S_FINISH && out_free && act_r == poasq_pkg::ACT_ADD
     && free_found_r) |-> !valid_r[free_idx_r])
    else $error("add overwrote a valid slot");

  // A committed pop removes a slot that was valid.
  a_pop_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == poasq_pkg::S_FINISH && out_free && act_r == poasq_pkg::ACT_POP
     && best.found) |-> valid_r[best_idx])
    else $error("pop chose an empty slot");

  // Candidates only arrive during a pop scan or its drain cycle.
  a_cand_window: assert property (@(posedge clk) disable iff (!rst_n)
    rd_vld_r |-> (act_r == poasq_pkg::ACT_POP &&
                  (state_r == poasq_pkg::S_SCAN || state_r == poasq_pkg::S_DRAIN)))
    else $error("compare candidate outside a pop scan");
`endif

endmodule

// ===== design/poasq_ram.sv =====
module poasq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== design/poasq_cmp.sv =====
module poasq_cmp #(
  parameter int SLOTS = poasq_pkg::SLOTS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  poasq_pkg::cmp_ctl_t      ctl,
  input  logic [$clog2(SLOTS)-1:0] cand_idx,
  input  poasq_pkg::entry_t        cand,
  output poasq_pkg::best_t         best,
  output logic [$clog2(SLOTS)-1:0] best_idx
);

  localparam int IW = $clog2(SLOTS);

  logic                found_r, found_nxt;
  poasq_pkg::entry_t   entry_r, entry_nxt;
  logic [IW-1:0]       idx_r, idx_nxt;
  logic                better;
  logic                take;

  // Strict compare, so an equal later slot never displaces an earlier one.
  always_comb begin
    if (ctl.mode == poasq_pkg::MODE_PRIO) begin
      better = cand.prio > entry_r.prio;
    end else begin
      better = cand.tstamp < entry_r.tstamp;
    end
    take      = ctl.cand_vld && (!found_r || better);
    found_nxt = found_r;
    entry_nxt = entry_r;
    idx_nxt   = idx_r;
    if (ctl.clear) begin
      found_nxt = 1'b0;
    end else if (take) begin
      found_nxt = 1'b1;
      entry_nxt = cand;
      idx_nxt   = cand_idx;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
    end else begin
      found_r <= found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
    idx_r   <= idx_nxt;
  end

  assign best.found = found_r;
  assign best.entry = entry_r;
  assign best_idx   = idx_r;

endmodule
